// ===== sv/pwmt_pkg.sv =====
package pwmt_pkg;

    localparam int CHANNELS      = 4;
    localparam int GLOBAL_OFFSET = 0;
    localparam int CHANNEL_BASE  = 16;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 8;
    localparam int MODE_W = 2;
    localparam int CTRL_W = 2;
    localparam int DONE_LSB = 4;

    // transaction kinds
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

    // register offsets within a channel window
    localparam logic [3:0] OFF_CTRL   = 4'h0;
    localparam logic [3:0] OFF_PERIOD = 4'h4;
    localparam logic [3:0] OFF_DUTY   = 4'h8;
    localparam logic [3:0] OFF_COUNT  = 4'hC;

    localparam logic [DATA_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic            is_global;
        logic            bad;
        logic [CH_W-1:0] chan;
        logic [3:0]      off;
    } t_dec;

    typedef struct packed {
        logic tick;
        logic wr_ctrl;
        logic wr_period;
        logic wr_duty;
        logic clr_done;
    } t_ch_cmd;

    typedef struct packed {
        logic [CTRL_W-1:0] control;
        logic              done;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] duty;
        logic [DATA_W-1:0] count_view;
    } t_ch_stat;

endpackage

// ===== sv/pwmt_if.sv =====
interface pwmt_req_if import pwmt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output mode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input address, input write_data,
                    output ready);
endinterface

interface pwmt_rsp_if import pwmt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              bad_address;

    modport source (output valid, output read_data, output bad_address, input ready);
    modport sink   (input valid, input read_data, input bad_address, output ready);
endinterface

// ===== sv/pwmt_decode.sv =====
module pwmt_decode import pwmt_pkg::*; (
    input  logic [ADDR_W-1:0] i_address,
    output t_dec              o_dec
);
    logic [ADDR_W-1:0] w_rel;
    logic [3:0]        w_chan_full;

    always_comb begin
        w_rel       = i_address - ADDR_W'(CHANNEL_BASE);
        w_chan_full = w_rel[7:4];
        o_dec.is_global = (i_address == ADDR_W'(GLOBAL_OFFSET));
        o_dec.chan      = w_chan_full[CH_W-1:0];
        o_dec.off       = w_rel[3:0];
        o_dec.bad       = 1'b0;
        if (!o_dec.is_global) begin
            if (i_address < ADDR_W'(CHANNEL_BASE)) begin
                o_dec.bad = 1'b1;
            end else if (w_chan_full >= 4'(CHANNELS)) begin
                o_dec.bad = 1'b1;
            end else begin
                case (o_dec.off)
                    OFF_CTRL, OFF_PERIOD, OFF_DUTY, OFF_COUNT: o_dec.bad = 1'b0;
                    default: o_dec.bad = 1'b1;
                endcase
            end
        end
    end
endmodule

// ===== sv/pwmt_channel.sv =====
module pwmt_channel import pwmt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ch_cmd           i_cmd,
    input  logic [DATA_W-1:0] i_data,
    output t_ch_stat          o_stat
);
    logic [CTRL_W-1:0] r_control, n_control;
    logic [DATA_W-1:0] r_period,  n_period;
    logic [DATA_W-1:0] r_duty,    n_duty;
    logic [DATA_W-1:0] r_count,   n_count;
    logic              r_done,    n_done;
    logic              r_armed,   n_armed;
    logic [DATA_W-1:0] w_inc;

    always_comb begin
        n_control = r_control;
        n_period  = r_period;
        n_duty    = r_duty;
        n_count   = r_count;
        n_done    = r_done;
        n_armed   = r_armed;
        w_inc     = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

        if (i_cmd.tick && r_control[0]) begin
            n_count = w_inc;
            if (r_armed && (w_inc >= r_period)) begin
                n_done  = 1'b1;
                n_armed = 1'b0;
            end
        end
        if (i_cmd.wr_ctrl) begin
            n_control = i_data[CTRL_W-1:0];
            if (!r_control[0] && i_data[0]) begin
                // rising enable: restart
                n_count = '0;
                n_done  = 1'b0;
                n_armed = (r_period != '0);
            end else if (r_control[0] && !i_data[0]) begin
                // disable keeps done
                n_count = '0;
                n_armed = 1'b0;
            end
        end
        if (i_cmd.wr_period) begin
            n_period = i_data;
            if (r_control[0]) begin
                n_count = '0;
                n_done  = 1'b0;
                n_armed = (i_data != '0);
            end
        end
        if (i_cmd.wr_duty) begin
            n_duty = i_data;
        end
        if (i_cmd.clr_done) begin
            n_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_period  <= '0;
            r_duty    <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
            r_armed   <= 1'b0;
        end else begin
            r_control <= n_control;
            r_period  <= n_period;
            r_duty    <= n_duty;
            r_count   <= n_count;
            r_done    <= n_done;
            r_armed   <= n_armed;
        end
    end

    always_comb begin
        o_stat.control = r_control;
        o_stat.done    = r_done;
        o_stat.period  = r_period;
        o_stat.duty    = r_duty;
        if (!r_control[0]) begin
            o_stat.count_view = '0;
        end else if ((r_period != '0) && (r_count > r_period)) begin
            o_stat.count_view = r_period;
        end else begin
            o_stat.count_view = r_count;
        end
    end
endmodule

// ===== sv/four_channel_pwm_timer_registers_core.sv =====
// Four-channel register-mapped timer core.
//
// i_req carries one transaction per handshake: a timer tick, a bus read or
// a bus write (mode, address, write_data). o_rsp returns exactly one
// transaction for each request, in order: read_data and bad_address.
//
// A request accepted into the request register is decoded and applied to
// the channel registers when it moves into the response register, which
// loads at that edge; the response is on o_rsp from that edge on.
// Throughput is one transaction per cycle while o_rsp does not stall, set
// by the single decode / update pass between the request register and the response register.
//
// Reset (synchronous, active low) clears every channel's control, period,
// duty, count, done and arming, and empties both pipeline registers.
//
// When o_rsp stalls, the response register holds; the request register
// still takes one more transaction, then i_req.ready drops until the
// response is taken. Channel state only changes when a request moves
// into the response register, so stalls never drop or repeat a tick.
module four_channel_pwm_timer_registers_core import pwmt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pwmt_req_if.sink  i_req,
    pwmt_rsp_if.source o_rsp
);
    // request register
    logic              r_s1_valid;
    logic [MODE_W-1:0] r_s1_mode;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [DATA_W-1:0] r_s1_data;

    // response register
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic              r_out_bad,  n_out_bad;

    logic     w_out_free;
    logic     w_adv;
    logic     w_is_rd;
    logic     w_is_wr;
    t_dec     w_dec;
    t_ch_cmd  w_cmd  [CHANNELS];
    t_ch_stat w_stat [CHANNELS];
    logic [DATA_W-1:0] w_global;
    t_ch_stat          w_sel;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_adv       = r_s1_valid && w_out_free;
    assign i_req.ready = !r_s1_valid || w_out_free;

    assign w_is_rd = (r_s1_mode == MODE_READ);
    assign w_is_wr = (r_s1_mode == MODE_WRITE);

    pwmt_decode u_decode (
        .i_address (r_s1_addr),
        .o_dec     (w_dec)
    );

    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_ch
            logic w_hit;
            assign w_hit = w_adv && w_is_wr && !w_dec.is_global && !w_dec.bad &&
                           (w_dec.chan == CH_W'(g));
            assign w_cmd[g].tick      = w_adv && (r_s1_mode == MODE_TICK);
            assign w_cmd[g].wr_ctrl   = w_hit && (w_dec.off == OFF_CTRL);
            assign w_cmd[g].wr_period = w_hit && (w_dec.off == OFF_PERIOD);
            assign w_cmd[g].wr_duty   = w_hit && (w_dec.off == OFF_DUTY);
            // write-one-to-clear of the done flags in the global register
            assign w_cmd[g].clr_done  = w_adv && w_is_wr && w_dec.is_global &&
                                        r_s1_data[DONE_LSB + g];

            pwmt_channel u_channel (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd[g]),
                .i_data  (r_s1_data),
                .o_stat  (w_stat[g])
            );
        end
    endgenerate

    // global status view: enables low nibble, done flags high nibble
    always_comb begin
        w_global = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            w_global[i]            = w_stat[i].control[0];
            w_global[DONE_LSB + i] = w_stat[i].done;
        end
    end

    assign w_sel = w_stat[w_dec.chan];

    // read mux; mode 3 and ticks give zeros
    always_comb begin
        n_out_data = '0;
        n_out_bad  = (w_is_rd || w_is_wr) && w_dec.bad;
        if (w_is_rd && !w_dec.bad) begin
            if (w_dec.is_global) begin
                n_out_data = w_global;
            end else begin
                case (w_dec.off)
                    OFF_CTRL:   n_out_data = DATA_W'(w_sel.control);
                    OFF_PERIOD: n_out_data = w_sel.period;
                    OFF_DUTY:   n_out_data = w_sel.duty;
                    OFF_COUNT:  n_out_data = w_sel.count_view;
                    default:    n_out_data = '0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s1_mode <= i_req.mode;
            r_s1_addr <= i_req.address;
            r_s1_data <= i_req.write_data;
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
            r_out_bad  <= n_out_bad;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_data   = r_out_data;
    assign o_rsp.bad_address = r_out_bad;

    // an accepted request always occupies the request register next cycle
    a_req_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_s1_valid)
        else $error("accepted request lost");

    // a request that advances always produces a response
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("response missing after advance");

    // a bad access never returns data
    a_bad_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_bad |-> (r_out_data == '0))
        else $error("bad address returned data");

endmodule

// ===== verif/pwmt_checker.sv =====
`timescale 1ns / 1ps

module pwmt_checker import pwmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pwmt_req_if  i_req,
    pwmt_rsp_if  i_rsp,
    output int   o_pending,
    output int   o_fail_count
);

    localparam int CH_STRIDE = 16;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              bad_address;
    } t_timer_rsp;

    // Shadow copy of the timer registers
    logic [CTRL_W-1:0] ctl_q    [CHANNELS];
    logic [DATA_W-1:0] period_q [CHANNELS];
    logic [DATA_W-1:0] duty_q   [CHANNELS];
    logic [DATA_W-1:0] ticks_q  [CHANNELS];
    logic              done_q   [CHANNELS];
    logic              armed_q  [CHANNELS];

    t_timer_rsp expected_rsp_q [$];
    t_timer_rsp got_rsp;
    t_timer_rsp want_rsp;
    int         new_fails;

    function automatic void restart_channel(input int ch);
        ticks_q[ch] = '0;
        done_q[ch]  = 1'b0;
        armed_q[ch] = (period_q[ch] != '0);
    endfunction

    function automatic logic [DATA_W-1:0] visible_count(input int ch);
        if (!ctl_q[ch][0])
            return '0;
        if (period_q[ch] != '0 && ticks_q[ch] > period_q[ch])
            return period_q[ch];
        return ticks_q[ch];
    endfunction

    // Applies one request to the shadow state and returns its response.
    function automatic t_timer_rsp apply_request(input logic [MODE_W-1:0] mode,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [DATA_W-1:0] data);
        t_timer_rsp r;
        int         rel;
        int         ch;
        logic [3:0] off;
        logic       was_en;
        r = '0;
        if (mode == MODE_TICK) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (ctl_q[i][0]) begin
                    if (ticks_q[i] != COUNT_MAX)
                        ticks_q[i] = ticks_q[i] + 1;
                    if (armed_q[i] && ticks_q[i] >= period_q[i]) begin
                        done_q[i]  = 1'b1;
                        armed_q[i] = 1'b0;
                    end
                end
            end
        end else if (mode == MODE_READ || mode == MODE_WRITE) begin
            if (int'(addr) == GLOBAL_OFFSET) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (mode == MODE_READ) begin
                        r.read_data[i]          = ctl_q[i][0];
                        r.read_data[DONE_LSB+i] = done_q[i];
                    end else if (data[DONE_LSB+i]) begin
                        done_q[i] = 1'b0;
                    end
                end
            end else if (int'(addr) < CHANNEL_BASE) begin
                r.bad_address = 1'b1;
            end else begin
                rel = int'(addr) - CHANNEL_BASE;
                ch  = rel / CH_STRIDE;
                off = 4'(rel % CH_STRIDE);
                if (ch >= CHANNELS || !(off inside {OFF_CTRL, OFF_PERIOD, OFF_DUTY, OFF_COUNT})) begin
                    r.bad_address = 1'b1;
                end else if (mode == MODE_READ) begin
                    case (off)
                        OFF_CTRL:   r.read_data = DATA_W'(ctl_q[ch]);
                        OFF_PERIOD: r.read_data = period_q[ch];
                        OFF_DUTY:   r.read_data = duty_q[ch];
                        default:    r.read_data = visible_count(ch);
                    endcase
                end else begin
                    case (off)
                        OFF_CTRL: begin
                            was_en    = ctl_q[ch][0];
                            ctl_q[ch] = data[CTRL_W-1:0];
                            if (!was_en && ctl_q[ch][0]) begin
                                restart_channel(ch);
                            end else if (was_en && !ctl_q[ch][0]) begin
                                ticks_q[ch] = '0;
                                armed_q[ch] = 1'b0;
                            end
                        end
                        OFF_PERIOD: begin
                            period_q[ch] = data;
                            if (ctl_q[ch][0])
                                restart_channel(ch);
                        end
                        OFF_DUTY: duty_q[ch] = data;
                        default: ;  // count is read-only
                    endcase
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                ctl_q[i]    = '0;
                period_q[i] = '0;
                duty_q[i]   = '0;
                ticks_q[i]  = '0;
                done_q[i]   = 1'b0;
                armed_q[i]  = 1'b0;
            end
            expected_rsp_q.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            new_fails = 0;
            if (i_req.valid && i_req.ready)
                expected_rsp_q.push_back(apply_request(i_req.mode, i_req.address,
                                                       i_req.write_data));
            if (i_rsp.valid && i_rsp.ready) begin
                got_rsp.read_data   = i_rsp.read_data;
                got_rsp.bad_address = i_rsp.bad_address;
                if (expected_rsp_q.size() == 0) begin
                    $display("%0t: response with none expected: expected none, got %h/%b",
                             $time, got_rsp.read_data, got_rsp.bad_address);
                    new_fails++;
                end else begin
                    want_rsp = expected_rsp_q.pop_front();
                    if (got_rsp.read_data !== want_rsp.read_data) begin
                        $display("%0t: read_data expected %h, got %h",
                                 $time, want_rsp.read_data, got_rsp.read_data);
                        new_fails++;
                    end
                    if (got_rsp.bad_address !== want_rsp.bad_address) begin
                        $display("%0t: bad_address expected %b, got %b",
                                 $time, want_rsp.bad_address, got_rsp.bad_address);
                        new_fails++;
                    end
                end
            end
            o_pending    <= expected_rsp_q.size();
            o_fail_count <= o_fail_count + new_fails;
        end
    end

endmodule

// ===== verif/tb_four_channel_pwm_timer_registers_core.sv =====
`timescale 1ns / 1ps

module tb_four_channel_pwm_timer_registers_core;
    import pwmt_pkg::*;

    // Spare mode code: the block must treat it as a no-op
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CH_STRIDE    = 16;
    localparam int RANDOM_ITEMS = 1150;
    localparam int PAUSE_AT     = 600;   // sender drains the block here
    localparam int HOLD_AT      = 150;   // receiver blocks for a long stretch here
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [3:0] REG_OFFS [4] = '{OFF_CTRL, OFF_PERIOD, OFF_DUTY, OFF_COUNT};

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    int   sent_count;
    int   cycle_count = 0;

    pwmt_req_if req_if ();
    pwmt_rsp_if rsp_if ();

    four_channel_pwm_timer_registers_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predicts every response and compares it; hands back the failure
    // count and how many responses are still owed.
    pwmt_checker u_rsp_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Hard stop in case the block locks up
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("four_channel_pwm_timer_registers_core: mismatch");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] chan_addr(input int ch, input logic [3:0] off);
        return ADDR_W'(CHANNEL_BASE + CH_STRIDE * ch + int'(off));
    endfunction

    // One request transaction. The gap before it is drawn per item, except in
    // every third block of fifty items where the sender runs back to back.
    // valid is left high after acceptance so back-to-back items never drop it.
    task automatic issue_request(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a,
                                 input logic [DATA_W-1:0] d);
        int gap;
        gap = (((sent_count / 50) % 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.mode       <= m;
        req_if.address    <= a;
        req_if.write_data <= d;
        do @(posedge i_clk); while (!req_if.ready);
        sent_count++;
    endtask

    // Stop offering and wait until every owed response has been taken. The
    // first edge lets the checker's count catch up with the last transaction.
    task automatic drain_block();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly legal register traffic with small periods so that channels
    // actually expire; ticks carry random address and data, which must be
    // ignored. A small share is pure noise over the whole map and all modes.
    task automatic draw_random_access(output logic [MODE_W-1:0] m,
                                      output logic [ADDR_W-1:0] a,
                                      output logic [DATA_W-1:0] d);
        int         kind;
        logic [3:0] off;
        kind = $urandom_range(0, 99);
        off  = REG_OFFS[$urandom_range(0, 3)];
        a    = chan_addr($urandom_range(0, CHANNELS - 1), off);
        d    = $urandom;
        if (kind < 40) begin
            m = MODE_TICK;
            if ($urandom_range(0, 3) == 0)
                a = ADDR_W'($urandom_range(0, 255));
        end else if (kind < 62) begin
            m = MODE_READ;
            if ($urandom_range(0, 9) == 0)
                a = ADDR_W'(GLOBAL_OFFSET);
        end else if (kind < 85) begin
            m = MODE_WRITE;
            if (off == OFF_PERIOD && $urandom_range(0, 9) < 7)
                d = $urandom_range(0, 12);
            else if (off == OFF_CTRL && $urandom_range(0, 4) != 0)
                d = $urandom_range(0, 3);
        end else if (kind < 92) begin
            // clear a random set of done flags
            m = MODE_WRITE;
            a = ADDR_W'(GLOBAL_OFFSET);
        end else begin
            m = MODE_W'($urandom_range(0, 3));
            a = ADDR_W'($urandom_range(0, 255));
        end
    endtask

    // Response side: stalls drawn per transaction, with its own stretches of
    // no stalling, and one long hold-off so the request side fills and blocks.
    initial begin : rsp_sink
        int stall;
        int taken;
        taken = 0;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else if (((taken / 50) % 3) == 1)
                stall = 0;
            else
                stall = $urandom_range(0, 11);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            taken++;
        end
    end

    initial begin : req_source
        logic [MODE_W-1:0] m;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        sent_count = 0;
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.mode       <= MODE_TICK;
        req_if.address    <= '0;
        req_if.write_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset values, expiry and capping, restarts, zero period,
        // read-only count, the bad address classes and the spare mode.
        issue_request(MODE_READ,  ADDR_W'(GLOBAL_OFFSET), '0);
        issue_request(MODE_READ,  chan_addr(0, OFF_COUNT), '0);        // disabled reads zero
        issue_request(MODE_WRITE, chan_addr(0, OFF_PERIOD), 32'd3);    // stored only
        issue_request(MODE_WRITE, chan_addr(0, OFF_CTRL), 32'd3);      // rising enable
        repeat (4) issue_request(MODE_TICK, '1, '1);                   // expires at three
        issue_request(MODE_READ,  chan_addr(0, OFF_COUNT), '0);        // capped at period
        issue_request(MODE_READ,  ADDR_W'(GLOBAL_OFFSET), '0);
        issue_request(MODE_WRITE, chan_addr(0, OFF_CTRL), 32'd1);      // no restart
        issue_request(MODE_WRITE, ADDR_W'(GLOBAL_OFFSET), '1);         // clear all done
        issue_request(MODE_WRITE, chan_addr(1, OFF_CTRL), 32'd1);      // zero period
        issue_request(MODE_TICK,  '0, '0);
        issue_request(MODE_READ,  chan_addr(1, OFF_COUNT), '0);        // raw count
        issue_request(MODE_WRITE, chan_addr(0, OFF_COUNT), '1);        // ignored, not bad
        issue_request(MODE_READ,  8'h01, '0);                          // below channel base
        issue_request(MODE_READ,  8'h0F, '0);
        issue_request(MODE_READ,  8'h50, '0);                          // channel out of range
        issue_request(MODE_WRITE, chan_addr(2, 4'h2), '1);             // hole in the window
        issue_request(MODE_READ,  8'hFF, '0);
        issue_request(MODE_UNUSED, chan_addr(0, OFF_CTRL), '1);
        issue_request(MODE_WRITE, chan_addr(3, OFF_DUTY), '1);
        issue_request(MODE_WRITE, chan_addr(0, OFF_PERIOD), '1);       // restart while enabled
        issue_request(MODE_WRITE, chan_addr(0, OFF_CTRL), 32'd2);      // disable, done kept
        drain_block();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT)
                drain_block();
            draw_random_access(m, a, d);
            issue_request(m, a, d);
        end
        drain_block();
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("four_channel_pwm_timer_registers_core: match");
        else
            $display("four_channel_pwm_timer_registers_core: mismatch");
        $finish;
    end

endmodule
